FILE: sv/dqrk_pkg.sv
// Shared constants, codes and helpers of the keyed deque.
`default_nettype none
package dqrk_pkg;

  // Storage geometry
  localparam int Depth  = 16;
  localparam int IdBits = 16;
  localparam int AddrW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);

  // Port field widths
  localparam int ModeW   = 3;
  localparam int IdW     = 16;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4,
    MODE_FIND       = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  // Circular address: base plus offset, wrapped once at Depth.
  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] base,
                                               input logic [AddrW-1:0] off);
    logic [AddrW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AddrW+1)'(Depth)) begin
      sum = sum - (AddrW+1)'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

  // Circular address one slot before base.
  function automatic logic [AddrW-1:0] wrap_dec(input logic [AddrW-1:0] base);
    logic [AddrW-1:0] res;
    if (base == '0) begin
      res = AddrW'(Depth - 1);
    end else begin
      res = base - AddrW'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/dqrk_if.sv
// Request and response channel interfaces of the keyed deque.
`default_nettype none
interface dqrk_req_if;
  logic                       valid;
  logic                       ready;
  logic [dqrk_pkg::ModeW-1:0] mode;
  logic [dqrk_pkg::IdW-1:0]   entity_id;

  modport source (output valid, mode, entity_id, input ready);
  modport sink (input valid, mode, entity_id, output ready);
endinterface

interface dqrk_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dqrk_pkg::StatusW-1:0] status;
  logic [dqrk_pkg::IdW-1:0]     result_id;
  logic [dqrk_pkg::CountW-1:0]  count;

  modport source (output valid, status, result_id, count, input ready);
  modport sink (input valid, status, result_id, count, output ready);
endinterface
`default_nettype wire

FILE: sv/dqrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqrk_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/deque_with_remove_by_key_top.sv
// Keyed double-ended queue of entity IDs: sequencer around one RAM and one comparator.
//
//   req_i carries one operation per beat (mode, entity_id); rsp_o returns exactly
//   one beat per request (status, result_id, count after the operation).
//   Entries live in a circular buffer in one RAM (one write port, registered read);
//   a head pointer and a count give front and back.
//   A push writes its slot when the request is accepted; a pop reads the front
//   or back slot into the reply and shrinks the queue. Find and remove scan from
//   the front until the first match, or through all entries without one; a remove
//   with a match then shifts each later entry down one slot to close the gap. Full
//   or empty cases and unused modes leave the queue unchanged and go to the response.
//   Scan and gap closing both go one slot per cycle through the RAM read port;
//   the scan also uses the shared ID comparator. req_i.ready is high only while
//   the sequencer is idle, and it rises in the cycle the response turns valid:
//   one operation is worked on at a time. A stalled rsp_o holds its beat; the next
//   request is still accepted and worked on, and only its final step waits for the
//   beat to drain.
//   Reset empties the queue and drops any pending response; RAM is not cleared.
`default_nettype none
module deque_with_remove_by_key_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  dqrk_req_if.sink   req_i,
  dqrk_rsp_if.source rsp_o
);
  import dqrk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POPW,
    ST_CMP,
    ST_SHR,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [IdBits-1:0] id_q, id_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  status_e           st_q, st_d;
  logic [IdBits-1:0] rid_q, rid_d;

  // Output register
  logic              ov_q, ov_d;
  status_e           ost_q, ost_d;
  logic [IdBits-1:0] orid_q, orid_d;
  logic [CntW-1:0]   ocnt_q, ocnt_d;

  // RAM port
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [IdBits-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [IdBits-1:0] ram_rdata;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              at_last;
  logic              id_match;
  logic              out_free;
  logic [AddrW-1:0]  last_off;
  logic [AddrW-1:0]  idx_inc;

  dqrk_ram #(
    .Width(IdBits),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign is_full  = (cnt_q == CntW'(Depth));
  assign is_empty = (cnt_q == '0);
  // Offset of the back entry; only used when the queue holds something
  assign last_off = AddrW'(cnt_q - CntW'(1));
  assign at_last  = (idx_q == last_off);
  assign idx_inc  = idx_q + AddrW'(1);
  // Shared comparator: stored entry against the search key
  assign id_match = (ram_rdata == id_q);
  assign out_free = !ov_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    id_d      = id_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    st_d      = st_q;
    rid_d     = rid_q;
    ov_d      = ov_q;
    ost_d     = ost_q;
    orid_d    = orid_q;
    ocnt_d    = ocnt_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = id_q;
    ram_raddr = head_q;

    // Drop the response once the sink takes it
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d  = mode_e'(req_i.mode);
          id_d    = req_i.entity_id[IdBits-1:0];
          st_d    = STATUS_DONE;
          rid_d   = '0;
          idx_d   = '0;
          state_d = ST_FIN;
          unique case (mode_e'(req_i.mode)) inside
            MODE_PUSH_FRONT: begin
              if (is_full) begin
                st_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_dec(head_q);
                ram_wdata = req_i.entity_id[IdBits-1:0];
                head_d    = wrap_dec(head_q);
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            MODE_PUSH_BACK: begin
              if (is_full) begin
                st_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_q, AddrW'(cnt_q));
                ram_wdata = req_i.entity_id[IdBits-1:0];
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (is_empty) begin
                st_d = STATUS_EMPTY;
              end else begin
                if (mode_e'(req_i.mode) == MODE_POP_BACK) begin
                  ram_raddr = wrap_add(head_q, last_off);
                end else begin
                  ram_raddr = head_q;
                end
                state_d = ST_POPW;
              end
            end
            MODE_REMOVE, MODE_FIND: begin
              if (is_empty) begin
                st_d = STATUS_EMPTY;
              end else begin
                // Issue the read of the front slot
                ram_raddr = head_q;
                state_d   = ST_CMP;
              end
            end
            default: begin
              // Unused modes leave the queue untouched
            end
          endcase
        end
      end

      ST_POPW: begin
        rid_d = ram_rdata;
        cnt_d = cnt_q - CntW'(1);
        if (mode_q == MODE_POP_FRONT) begin
          head_d = wrap_add(head_q, AddrW'(1));
        end
        state_d = ST_FIN;
      end

      ST_CMP: begin
        if (id_match) begin
          rid_d = ram_rdata;
          if (mode_q == MODE_FIND || at_last) begin
            if (mode_q == MODE_REMOVE) begin
              cnt_d = cnt_q - CntW'(1);
            end
            state_d = ST_FIN;
          end else begin
            // Start closing the gap: fetch the slot behind the match
            ram_raddr = wrap_add(head_q, idx_inc);
            state_d   = ST_SHR;
          end
        end else if (at_last) begin
          st_d    = STATUS_NOTFOUND;
          state_d = ST_FIN;
        end else begin
          idx_d     = idx_inc;
          ram_raddr = wrap_add(head_q, idx_inc);
        end
      end

      ST_SHR: begin
        // Move slot idx+1 down into slot idx
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_inc;
        if (idx_inc == last_off) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_FIN;
        end else begin
          ram_raddr = wrap_add(head_q, idx_inc + AddrW'(1));
        end
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          orid_d  = rid_q;
          ocnt_d  = cnt_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_PUSH_FRONT;
      id_q    <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      st_q    <= STATUS_DONE;
      rid_q   <= '0;
      ov_q    <= 1'b0;
      ost_q   <= STATUS_DONE;
      orid_q  <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      id_q    <= id_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      st_q    <= st_d;
      rid_q   <= rid_d;
      ov_q    <= ov_d;
      ost_q   <= ost_d;
      orid_q  <= orid_d;
      ocnt_q  <= ocnt_d;
    end
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.status    = ost_q;
  assign rsp_o.result_id = IdW'(orid_q);
  assign rsp_o.count     = CountW'(ocnt_q);

endmodule
`default_nettype wire

FILE: sv/dqrk_checker.sv
// Port-level assertions of the keyed deque, bound to its top level.
`default_nettype none
module dqrk_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         req_valid_i,
  input wire logic                         req_ready_i,
  input wire logic                         rsp_valid_i,
  input wire logic                         rsp_ready_i,
  input wire logic [dqrk_pkg::StatusW-1:0] rsp_status_i,
  input wire logic [dqrk_pkg::IdW-1:0]     rsp_result_id_i,
  input wire logic [dqrk_pkg::CountW-1:0]  rsp_count_i
);
  import dqrk_pkg::*;

  // One request in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_result_id_i) && $stable(rsp_count_i))
    else $error("stalled response beat changed");

  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= CountW'(Depth))
    else $error("count above capacity");

  // Full status only with a full queue, and with no ID
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_FULL
      |-> rsp_count_i == CountW'(Depth) && rsp_result_id_i == '0)
    else $error("full status with a queue that is not full");

  // Empty status only with an empty queue, and with no ID
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_EMPTY
      |-> rsp_count_i == '0 && rsp_result_id_i == '0)
    else $error("empty status with a queue that is not empty");

endmodule

bind deque_with_remove_by_key_top dqrk_checker u_dqrk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_result_id_i(rsp_o.result_id),
  .rsp_count_i    (rsp_o.count)
);
`default_nettype wire

FILE: bench/dqrk_op_checker.sv
// Checker of the keyed deque: mirrors the queue, predicts each reply and compares it.
module dqrk_op_checker
  import dqrk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dqrk_req_if        req_i,
  dqrk_rsp_if        rsp_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrintLimit = 40;

  typedef struct packed {
    status_e             status;
    logic [IdW-1:0]      result_id;
    logic [CountW-1:0]   count;
  } deque_reply_t;

  logic [IdBits-1:0] mirror_ids[$];
  deque_reply_t      pending_replies[$];
  deque_reply_t      want;
  int                reply_beats;

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= PrintLimit) begin
      $display("[%0t] reply beat %0d: %s", $realtime, reply_beats, what);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, exp_val));
    end
  endtask

  // Apply one operation to the mirror and return the reply it must produce.
  function automatic deque_reply_t apply_queue_op(input logic [ModeW-1:0] mode,
                                                  input logic [IdW-1:0]   raw_id);
    deque_reply_t      reply;
    logic [IdBits-1:0] key;
    int                hit;
    reply = '{status: STATUS_DONE, result_id: '0, count: '0};
    key   = IdBits'(raw_id);
    hit   = -1;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (mirror_ids.size() >= Depth) begin
          reply.status = STATUS_FULL;
        end else if (mode == MODE_PUSH_FRONT) begin
          mirror_ids.push_front(key);
        end else begin
          mirror_ids.push_back(key);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (mirror_ids.size() == 0) begin
          reply.status = STATUS_EMPTY;
        end else if (mode == MODE_POP_FRONT) begin
          reply.result_id = IdW'(mirror_ids.pop_front());
        end else begin
          reply.result_id = IdW'(mirror_ids.pop_back());
        end
      end
      MODE_REMOVE, MODE_FIND: begin
        // scan from the front, first match wins
        foreach (mirror_ids[i]) begin
          if (hit < 0 && mirror_ids[i] == key) begin
            hit = i;
          end
        end
        if (mirror_ids.size() == 0) begin
          reply.status = STATUS_EMPTY;
        end else if (hit < 0) begin
          reply.status = STATUS_NOTFOUND;
        end else begin
          reply.result_id = IdW'(mirror_ids[hit]);
          if (mode == MODE_REMOVE) begin
            mirror_ids.delete(hit);
          end
        end
      end
      default: ;
    endcase
    reply.count = CountW'(mirror_ids.size());
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_ids.delete();
      pending_replies.delete();
      reply_beats      = 0;
      mismatch_count_o = 0;
      outstanding_o   <= 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        reply_beats++;
        if (pending_replies.size() == 0) begin
          report_mismatch("reply beat with no request outstanding");
        end else begin
          want = pending_replies.pop_front();
          check_field("status", rsp_i.status, want.status);
          check_field("result_id", rsp_i.result_id, want.result_id);
          check_field("count", rsp_i.count, want.count);
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        pending_replies.push_back(apply_queue_op(req_i.mode, req_i.entity_id));
      end
      outstanding_o <= pending_replies.size();
    end
  end

endmodule

FILE: bench/tb_deque_with_remove_by_key_top.sv
// Testbench top of the keyed deque: stimulus, reply back-pressure and verdict.
module tb_deque_with_remove_by_key_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dqrk_pkg::*;

  // Mode codes the block must ignore.
  localparam logic [ModeW-1:0] ModeUnusedLo = 3'd6;
  localparam logic [ModeW-1:0] ModeUnusedHi = 3'd7;

  localparam int RandomOps   = 1900;
  localparam int OpsPerPhase = 60;
  localparam int KeyPoolSize = 4;
  // Quiet time after the drain, sized from Depth, in which stray replies would show.
  localparam int SettleCycles = Depth + 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_count;
  int   outstanding;

  // Percent chance of a gap ahead of each request beat; changed per phase.
  int   gap_pct;

  dqrk_req_if req_ch ();
  dqrk_rsp_if rsp_ch ();

  deque_with_remove_by_key_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  dqrk_op_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // Send one request beat and return at the edge that accepts it. Call at a
  // rising edge. Ready is sampled mid-cycle, where it is stable, so the
  // acceptance edge is known without racing the block's own update.
  task automatic send_op(input logic [ModeW-1:0] op, input logic [IdW-1:0] key);
    int   gap;
    logic accepted;
    gap = 0;
    if ($urandom_range(99) < gap_pct) begin
      // mostly short gaps, now and then a long one
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
    end
    if (gap > 0) begin
      // drop valid and scribble the payload so only the handshake qualifies it
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= ModeW'($urandom);
      req_ch.entity_id <= IdW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= op;
    req_ch.entity_id <= key;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = (req_ch.ready === 1'b1);
      @(posedge clk_i);
    end
  endtask

  // Reply side: alternate ready-high and ready-low stretches of random length.
  // Long high stretches give runs with no back-pressure at all.
  initial begin
    int   run;
    logic level;
    forever begin
      level = ($urandom_range(3) != 0);
      if (level) begin
        run = ($urandom_range(7) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 1);
      end else begin
        run = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
      end
      rsp_ch.ready <= level;
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin
    logic [IdW-1:0]   key_pool [KeyPoolSize];
    logic [ModeW-1:0] op;
    logic [IdW-1:0]   key;
    int               issued;
    int               push_pct;
    int               roll;

    rst_ni           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_FIND;
    req_ch.entity_id <= '0;
    gap_pct = 25;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pops, remove and find against an empty queue.
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '1);
    send_op(MODE_REMOVE, '0);
    send_op(MODE_FIND, '1);
    // unused modes leave the queue alone
    send_op(ModeUnusedLo, 16'h1234);
    send_op(ModeUnusedHi, '1);

    // Fill to the brim with the ID extremes and a duplicate of each.
    send_op(MODE_PUSH_FRONT, '1);
    send_op(MODE_PUSH_BACK, '0);
    for (int k = 0; k < Depth - 2; k++) begin
      send_op(MODE_PUSH_BACK, (k == 5) ? IdW'('1) :
                              (k == 9) ? IdW'(0)  : IdW'(16'h5A5A ^ (16'h1 << k)));
    end
    // push into a full queue on either end
    send_op(MODE_PUSH_FRONT, 16'hBEEF);
    send_op(MODE_PUSH_BACK, 16'hBEEF);

    // first match wins: find at the front, remove just behind it
    send_op(MODE_FIND, '1);
    send_op(MODE_REMOVE, '0);
    send_op(MODE_FIND, 16'hBEEF);
    send_op(MODE_REMOVE, 16'hBEEF);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);

    // Random phases. Each phase picks a gap density, a push bias that drives
    // the queue toward full or empty, and a small key pool so that finds and
    // removes hit often, duplicates included.
    issued = 0;
    while (issued < RandomOps) begin
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(2))
        0:       push_pct = 60;
        1:       push_pct = 25;
        default: push_pct = 40;
      endcase
      foreach (key_pool[i]) begin
        case ($urandom_range(7))
          0:       key_pool[i] = '0;
          1:       key_pool[i] = '1;
          default: key_pool[i] = IdW'($urandom);
        endcase
      end

      for (int n = 0; n < OpsPerPhase && issued < RandomOps; n++) begin
        key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KeyPoolSize - 1)]
                                         : IdW'($urandom);
        roll = $urandom_range(99);
        if (roll < 3) begin
          // noise: ignored by the block, not counted
          op = $urandom_range(1) ? ModeUnusedHi : ModeUnusedLo;
        end else if (roll < 3 + push_pct) begin
          op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
          issued++;
        end else begin
          roll = $urandom_range(99);
          if (roll < 20) begin
            op = MODE_POP_FRONT;
          end else if (roll < 40) begin
            op = MODE_POP_BACK;
          end else if (roll < 75) begin
            op = MODE_REMOVE;
          end else begin
            op = MODE_FIND;
          end
          issued++;
        end
        send_op(op, key);
      end
    end

    // Hold valid low, drain every reply, then watch for strays.
    req_ch.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
